[rtl/core/tsrc_pkg.sv]
// Package for the terrain slope rule classifier: widths, CORDIC angle table, register indexes.
package tsrc_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int Z_BITS = 24;
	localparam int ANGLE_BITS = 11;
	localparam int ANGLE_SAT = 1440;
	localparam int RULE_REGS = 4;
	localparam int DIST_BITS = 17;

	typedef enum logic [2:0] {
		REG_SIZE_X = 3'd0,
		REG_SIZE_Y = 3'd1,
		REG_SIZE_DIAG = 3'd2,
		REG_RULE_COUNT = 3'd3,
		REG_RULE_0 = 3'd4,
		REG_RULE_1 = 3'd5,
		REG_RULE_2 = 3'd6,
		REG_RULE_3 = 3'd7
	} reg_idx_t;

	// atan(2^-i) in degrees, scaled by 2^16 (57.3 per radian)
	function automatic logic signed [Z_BITS-1:0] atan_step(input logic [3:0] i);
		logic signed [Z_BITS-1:0] t;
		begin
			case (i)
				4'd0: t = 24'sd2949337;
				4'd1: t = 24'sd1741095;
				4'd2: t = 24'sd919947;
				4'd3: t = 24'sd466979;
				4'd4: t = 24'sd234396;
				4'd5: t = 24'sd117312;
				4'd6: t = 24'sd58670;
				4'd7: t = 24'sd29337;
				4'd8: t = 24'sd14669;
				4'd9: t = 24'sd7334;
				4'd10: t = 24'sd3667;
				4'd11: t = 24'sd1834;
				4'd12: t = 24'sd917;
				4'd13: t = 24'sd458;
				4'd14: t = 24'sd229;
				4'd15: t = 24'sd115;
				default: t = '0;
			endcase
			return t;
		end
	endfunction

endpackage

[rtl/core/terrain_slope_rule_classifier.sv]
// Top level of the terrain slope rule classifier: register file, six CORDICs, max and rule match.
//
// Fully pipelined: a new cell may be started every cycle (busy is always low) and its result
// appears on done after one input register, 16 CORDIC rotation stages, two max-tree stages
// and one rule-compare stage. Results cannot be stalled; they are valid for the single cycle
// that done is high. Configuration writes also act on items already in flight; change registers
// only while no item is in flight.
module terrain_slope_rule_classifier #(
	parameter int MAX_RULES = 4,
	parameter int HEIGHT_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [HEIGHT_BITS-1:0] corner_a,
	input  logic signed [HEIGHT_BITS-1:0] corner_b,
	input  logic signed [HEIGHT_BITS-1:0] corner_c,
	input  logic signed [HEIGHT_BITS-1:0] corner_d,
	output logic                        done,
	output logic [10:0]                 max_slope_deg,
	output logic [3:0]                  rule_match_mask,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [4:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import tsrc_pkg::*;

	localparam int DH_BITS = HEIGHT_BITS + 1;
	localparam int LAT = CORDIC_STEPS + 4;
	localparam int ACT_RULES = (MAX_RULES < RULE_REGS) ? MAX_RULES : RULE_REGS;

	logic [15:0] size_x_q, size_y_q;
	logic [16:0] size_diag_q;
	logic [2:0]  rule_count_q;
	logic [21:0] rule_word_q [RULE_REGS];

	reg_idx_t widx;
	assign widx = reg_idx_t'(paddr[4:2]);
	assign pready = 1'b1;
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= 16'd256;
			size_y_q <= 16'd256;
			size_diag_q <= 17'd362;
			rule_count_q <= '0;
			for (int i = 0; i < RULE_REGS; i++) rule_word_q[i] <= '0;
		end else if (psel && penable && pwrite) begin
			case (widx)
				REG_SIZE_X:     size_x_q <= pwdata[15:0];
				REG_SIZE_Y:     size_y_q <= pwdata[15:0];
				REG_SIZE_DIAG:  size_diag_q <= pwdata[16:0];
				REG_RULE_COUNT: rule_count_q <= pwdata[2:0];
				REG_RULE_0:     rule_word_q[0] <= pwdata[21:0];
				REG_RULE_1:     rule_word_q[1] <= pwdata[21:0];
				REG_RULE_2:     rule_word_q[2] <= pwdata[21:0];
				REG_RULE_3:     rule_word_q[3] <= pwdata[21:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			REG_SIZE_X:     prdata = {16'd0, size_x_q};
			REG_SIZE_Y:     prdata = {16'd0, size_y_q};
			REG_SIZE_DIAG:  prdata = {15'd0, size_diag_q};
			REG_RULE_COUNT: prdata = {29'd0, rule_count_q};
			REG_RULE_0:     prdata = {10'd0, rule_word_q[0]};
			REG_RULE_1:     prdata = {10'd0, rule_word_q[1]};
			REG_RULE_2:     prdata = {10'd0, rule_word_q[2]};
			REG_RULE_3:     prdata = {10'd0, rule_word_q[3]};
			default:        prdata = '0;
		endcase
	end

	// stage 1: absolute differences
	logic [DH_BITS-1:0] dh_s1 [6];
	logic [LAT-1:0]     vld_q;

	function automatic logic [DH_BITS-1:0] absdiff(input logic signed [HEIGHT_BITS-1:0] p,
		input logic signed [HEIGHT_BITS-1:0] q);
		logic signed [DH_BITS-1:0] d;
		begin
			d = DH_BITS'(p) - DH_BITS'(q);
			return d[DH_BITS-1] ? DH_BITS'(-d) : d;
		end
	endfunction

	always_ff @(posedge clk) begin
		dh_s1[0] <= absdiff(corner_a, corner_b);
		dh_s1[1] <= absdiff(corner_b, corner_c);
		dh_s1[2] <= absdiff(corner_c, corner_d);
		dh_s1[3] <= absdiff(corner_d, corner_a);
		dh_s1[4] <= absdiff(corner_a, corner_c);
		dh_s1[5] <= absdiff(corner_b, corner_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[LAT-2:0], start};
	end

	logic [DIST_BITS-1:0] run_len [6];
	assign run_len[0] = {1'b0, size_x_q};
	assign run_len[1] = {1'b0, size_y_q};
	assign run_len[2] = {1'b0, size_x_q};
	assign run_len[3] = {1'b0, size_y_q};
	assign run_len[4] = size_diag_q;
	assign run_len[5] = size_diag_q;

	logic [ANGLE_BITS-1:0] ang [6];
	for (genvar k = 0; k < 6; k++) begin : g_cordic
		tsrc_cordic #(.DH_BITS(DH_BITS)) u_cordic (
			.clk(clk),
			.dh(dh_s1[k]), .run_len(run_len[k]), .angle(ang[k])
		);
	end

	// max tree over two stages
	logic [ANGLE_BITS-1:0] m_s18 [3];
	logic [ANGLE_BITS-1:0] m_s19;
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++)
			m_s18[k] <= (ang[2*k] > ang[2*k+1]) ? ang[2*k] : ang[2*k+1];
	end
	always_comb begin
		logic [ANGLE_BITS-1:0] t;
		t = (m_s18[0] > m_s18[1]) ? m_s18[0] : m_s18[1];
		m_s19 = (t > m_s18[2]) ? t : m_s18[2];
	end

	logic [ANGLE_BITS-1:0] best_s19;
	always_ff @(posedge clk) best_s19 <= m_s19;

	logic [3:0] mask_c;
	always_comb begin
		mask_c = '0;
		for (int i = 0; i < ACT_RULES; i++) begin
			if ((rule_count_q > 3'(i)) &&
				(rule_word_q[i][10:0] <= best_s19) && (best_s19 <= rule_word_q[i][21:11]))
				mask_c[i] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		max_slope_deg <= best_s19;
		rule_match_mask <= mask_c;
	end
	assign done = vld_q[LAT-1];

`ifndef SYNTHESIS
	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##20 done) else $error("result missing");
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> max_slope_deg <= 11'd1440) else $error("angle over saturation");
	a_mask_active: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rule_count_q == 3'd0) |-> rule_match_mask == 4'd0)
		else $error("mask bit set with no active rule");
`endif

endmodule

[rtl/core/tsrc_cordic.sv]
// Pipelined vectoring CORDIC: one rotation per stage, slope angle in degrees Q4 out.
module tsrc_cordic #(
	parameter int DH_BITS = 17
) (
	input  logic                               clk,
	input  logic [DH_BITS-1:0]                 dh,
	input  logic [tsrc_pkg::DIST_BITS-1:0]     run_len,
	output logic [tsrc_pkg::ANGLE_BITS-1:0]    angle
);
	import tsrc_pkg::*;

	// x grows to at most the CORDIC gain (~1.65) times the vector magnitude, under 2.4 x max(run_len, dh)
	localparam int MAG_BITS = (DH_BITS > DIST_BITS) ? DH_BITS : DIST_BITS;
	localparam int XY_BITS = MAG_BITS + 16 + 3;

	logic signed [XY_BITS-1:0] x_s [0:CORDIC_STEPS];
	logic signed [XY_BITS-1:0] y_s [0:CORDIC_STEPS];
	logic signed [Z_BITS-1:0]  z_s [0:CORDIC_STEPS];
	logic                      nz_s [0:CORDIC_STEPS];

	always_comb begin
		x_s[0] = $signed({{(XY_BITS-DIST_BITS-16){1'b0}}, run_len, 16'd0});
		y_s[0] = $signed({{(XY_BITS-DH_BITS-16){1'b0}}, dh, 16'd0});
		z_s[0] = '0;
		nz_s[0] = (dh != '0);
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
		logic signed [XY_BITS-1:0] xn, yn;
		logic signed [Z_BITS-1:0]  zn;
		always_comb begin
			if (!y_s[i][XY_BITS-1]) begin
				xn = x_s[i] + (y_s[i] >>> i);
				yn = y_s[i] - (x_s[i] >>> i);
				zn = z_s[i] + atan_step(4'(i));
			end else begin
				xn = x_s[i] - (y_s[i] >>> i);
				yn = y_s[i] + (x_s[i] >>> i);
				zn = z_s[i] - atan_step(4'(i));
			end
		end
		// payload pipeline, no reset needed
		always_ff @(posedge clk) begin
			x_s[i+1] <= xn;
			y_s[i+1] <= yn;
			z_s[i+1] <= zn;
			nz_s[i+1] <= nz_s[i];
		end
	end

	logic signed [Z_BITS-1:0] zr;
	logic [Z_BITS-13:0]       zq;
	always_comb begin
		zr = z_s[CORDIC_STEPS] + Z_BITS'(2048);
		zq = zr[Z_BITS-1:12];
		if (!nz_s[CORDIC_STEPS] || z_s[CORDIC_STEPS][Z_BITS-1])
			angle = '0;
		else if (zq > (Z_BITS-12)'(ANGLE_SAT))
			angle = ANGLE_BITS'(ANGLE_SAT);
		else
			angle = zq[ANGLE_BITS-1:0];
	end

endmodule

[tb/tb_top.sv]
// Testbench for the terrain slope rule classifier: CORDIC slope predictor, rule mask scoreboard.
`timescale 1ns / 1ps

module tb_top;
	import tsrc_pkg::*;

	localparam int LATENCY = 20;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [15:0] corner_a, corner_b, corner_c, corner_d;
	logic done;
	logic [10:0] max_slope_deg;
	logic [3:0] rule_match_mask;
	logic psel, penable, pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	terrain_slope_rule_classifier i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c), .corner_d(corner_d),
		.done(done), .max_slope_deg(max_slope_deg), .rule_match_mask(rule_match_mask),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	typedef struct packed {
		logic [10:0] angle;
		logic [3:0] mask;
	} slope_result_t;

	class slope_scoreboard;
		logic [15:0] size_x, size_y;
		logic [16:0] size_diag;
		logic [2:0] n_rules;
		logic [21:0] rules[4];
		slope_result_t pending[$];
		int mismatches;

		function void reset_regs();
			size_x = 256;
			size_y = 256;
			size_diag = 362;
			n_rules = 0;
			foreach (rules[i]) rules[i] = '0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [31:0] v);
			case (idx)
				REG_SIZE_X: size_x = v[15:0];
				REG_SIZE_Y: size_y = v[15:0];
				REG_SIZE_DIAG: size_diag = v[16:0];
				REG_RULE_COUNT: n_rules = v[2:0];
				default: rules[idx - REG_RULE_0] = v[21:0];
			endcase
		endfunction

		function longint floor_shr(longint v, int s);
			return v >>> s;
		endfunction

		function int slope_angle(longint dh, longint run_len);
			longint x, y, z, xs, ys;
			longint tbl[16] = '{2949337, 1741095, 919947, 466979, 234396, 117312, 58670,
				29337, 14669, 7334, 3667, 1834, 917, 458, 229, 115};
			z = 0;
			if (dh < 0) dh = -dh;
			if (dh == 0) return 0;
			x = run_len <<< 16;
			y = dh <<< 16;
			for (int i = 0; i < 16; i++) begin
				xs = floor_shr(x, i);
				ys = floor_shr(y, i);
				if (y >= 0) begin
					x = x + ys; y = y - xs; z += tbl[i];
				end else begin
					x = x - ys; y = y + xs; z -= tbl[i];
				end
			end
			if (z < 0) return 0;
			z = (z + 2048) >>> 12;
			return (z > 1440) ? 1440 : int'(z);
		endfunction

		function void note_cell(logic signed [15:0] a, b, c, d);
			longint la, lb, lc, ld;
			int best, s, act;
			slope_result_t r;
			la = a; lb = b; lc = c; ld = d;
			best = 0;
			s = slope_angle(la - lb, size_x); if (s > best) best = s;
			s = slope_angle(lb - lc, size_y); if (s > best) best = s;
			s = slope_angle(lc - ld, size_x); if (s > best) best = s;
			s = slope_angle(ld - la, size_y); if (s > best) best = s;
			s = slope_angle(la - lc, size_diag); if (s > best) best = s;
			s = slope_angle(lb - ld, size_diag); if (s > best) best = s;
			act = (n_rules > 4) ? 4 : n_rules;
			r.angle = best[10:0];
			r.mask = '0;
			for (int i = 0; i < act; i++)
				if (rules[i][10:0] <= best && best <= rules[i][21:11]) r.mask[i] = 1'b1;
			pending = {pending, r};
		endfunction

		function void check_result(logic [10:0] angle, logic [3:0] mask);
			slope_result_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result angle=%0d mask=%h", angle, mask);
				return;
			end
			e = pending.pop_front();
			if (e.angle !== angle || e.mask !== mask) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp angle=%0d mask=%h, got angle=%0d mask=%h",
						e.angle, e.mask, angle, mask);
			end
		endfunction
	endclass

	slope_scoreboard sb;
	int send_idle_pct;
	int stall_cycles;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		corner_a = '0; corner_b = '0; corner_c = '0; corner_d = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (done) sb.check_result(max_slope_deg, rule_match_mask);
		if ((start && !busy) || done) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
	end

	always @(posedge clk) begin
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("[terrain_slope_rule_classifier] ERROR");
			$finish;
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [31:0] v);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_reg(idx, v);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// one cell; start stays high across back-to-back items
	task automatic send_cell(logic [15:0] a, b, c, d);
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		corner_a <= a; corner_b <= b; corner_c <= c; corner_d <= d;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_cell(a, b, c, d);
	endtask

	task automatic random_cell();
		logic [15:0] base;
		int span;
		base = $urandom;
		case ($urandom_range(3))
			0: span = 65535;
			1: span = 2000;
			2: span = 64;
			default: span = 4;
		endcase
		if (span == 65535)
			send_cell($urandom, $urandom, $urandom, $urandom);
		else
			send_cell(base + $urandom_range(span), base + $urandom_range(span),
				base + $urandom_range(span), base + $urandom_range(span));
	endtask

	function automatic logic [31:0] rand_rule();
		logic [10:0] lo, hi;
		lo = $urandom_range(1440);
		hi = ($urandom_range(9) == 0) ? $urandom_range(2047) : lo + $urandom_range(400);
		return {10'b0, hi, lo};
	endfunction

	task automatic random_config(bit extreme);
		logic [31:0] sx, sy, sd;
		if (extreme) begin
			sx = $urandom_range(1) ? 32'd1 : 32'hFFFF_FFFF;
			sy = $urandom_range(1) ? 32'd0 : 32'd65535;
			sd = $urandom_range(1) ? 32'd92681 : 32'h1FFFF;
		end else begin
			sx = $urandom_range(1, 4096);
			sy = $urandom_range(1, 4096);
			sd = $urandom_range(1, 6000);
		end
		write_reg(REG_SIZE_X, sx);
		write_reg(REG_SIZE_Y, sy);
		write_reg(REG_SIZE_DIAG, sd);
		write_reg(REG_RULE_COUNT, $urandom_range(7));
		write_reg(REG_RULE_0, rand_rule());
		write_reg(REG_RULE_1, rand_rule());
		write_reg(REG_RULE_2, rand_rule());
		write_reg(REG_RULE_3, $urandom);
	endtask

	initial begin
		sb = new();
		sb.reset_regs();
		send_idle_pct = 15;
		stall_cycles = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults: no rules, flat, extremes
		send_cell(0, 0, 0, 0);
		send_cell(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
		send_cell(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_cell(16'hFFFF, 16'hFFFF, 0, 0);
		drain();
		write_reg(REG_RULE_0, {10'b0, 11'd1440, 11'd0});
		write_reg(REG_RULE_1, {10'b0, 11'd100, 11'd500});
		write_reg(REG_RULE_2, {10'b0, 11'd720, 11'd0});
		write_reg(REG_RULE_3, {10'b0, 11'd2047, 11'd720});
		write_reg(REG_RULE_COUNT, 3'd4);
		send_cell(0, 256, 256, 0);
		send_cell(0, 0, 1, 1);
		send_cell(16'h7FFF, 0, 0, 0);
		send_cell(100, 100, 100, 100);
		drain();
		write_reg(REG_SIZE_X, 0);
		write_reg(REG_SIZE_Y, 1);
		write_reg(REG_SIZE_DIAG, 0);
		write_reg(REG_RULE_COUNT, 3'd7);
		send_cell(0, 1, 0, 1);
		send_cell(0, 0, 0, 0);
		send_cell(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
		drain();
		write_reg(REG_SIZE_X, 65535);
		write_reg(REG_SIZE_Y, 65535);
		write_reg(REG_SIZE_DIAG, 17'h1FFFF);
		write_reg(REG_RULE_COUNT, 3'd2);
		send_cell(0, 1, 2, 3);
		send_cell(16'h8000, 16'h7FFF, 0, 1);

		for (int p = 0; p < 12; p++) begin
			start <= 1'b0;
			drain();
			random_config(p % 4 == 0);
			if (p == 4) send_idle_pct = 86;
			if (p == 8) send_idle_pct = 0;
			for (int n = 0; n < 150; n++) random_cell();
		end
		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		if (sb.mismatches == 0)
			$display("[terrain_slope_rule_classifier] OK");
		else
			$display("[terrain_slope_rule_classifier] ERROR");
		$finish;
	end
endmodule
